// ===== rtl/appc_pkg.sv =====
// Package for the addressed packet pressure controller.
// Holds sizes, codes and the job record passed from the control logic to the output stage.
// No dependencies.
package appc_pkg;

  localparam int CHANNELS      = 4;
  localparam int CAPTURE_BYTES = 2 * CHANNELS;
  localparam int REPLY_BYTES   = 2 + 2 * CHANNELS;
  localparam int CNT_W         = (CAPTURE_BYTES > 1) ? $clog2(CAPTURE_BYTES) : 1;
  localparam int REM_W         = $clog2(REPLY_BYTES);
  localparam int CH_IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMD_LIMIT     = 400;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_SAMPLE  = 2'd2;

  localparam logic OUT_VALVE = 1'b0;
  localparam logic OUT_REPLY = 1'b1;

  localparam logic CFG_ADDRESS = 1'b0;
  localparam logic CFG_GAIN    = 1'b1;

  typedef struct packed {
    logic                               valid;
    logic                               is_reply;
    logic [1:0]                         valve_channel;
    logic signed [9:0]                  valve_command;
    logic [REPLY_BYTES-1:0][7:0]        reply;
  } job_t;

endpackage

// ===== rtl/appc_ctrl.sv =====
// Packet framing, setpoint and pressure storage and the valve command computation.
// Depends on appc_pkg. Builds a job for each processed pressure sample and each completed capture.
module appc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pend_valid,
  input  logic                advance,
  input  logic [1:0]          kind,
  input  logic [7:0]          rx_byte,
  input  logic [1:0]          sample_channel,
  input  logic [9:0]          sample_value,
  input  logic [15:0]         device_address,
  input  logic [8:0]          gain,
  output appc_pkg::job_t      job
);

  logic [7:0]                          prior_byte;
  logic                                capturing;
  logic [appc_pkg::CNT_W-1:0]          capture_count;
  logic [7:0]                          capture_buffer [appc_pkg::CAPTURE_BYTES];
  logic [15:0]                         setpoint_store [appc_pkg::CHANNELS];
  logic [9:0]                          pressure_store [appc_pkg::CHANNELS];

  logic [appc_pkg::CH_IDX_W-1:0]       ch_sel;
  logic                                ch_ok;
  logic                                cap_done;
  logic                                addr_hit;
  logic [7:0]                          cap_full [appc_pkg::CAPTURE_BYTES];
  logic signed [16:0]                  diff;
  logic signed [26:0]                  prod;
  logic signed [9:0]                   cmd;

  assign ch_sel   = appc_pkg::CH_IDX_W'(sample_channel);
  assign ch_ok    = 32'(sample_channel) < appc_pkg::CHANNELS;
  assign cap_done = capturing &&
                    (capture_count == appc_pkg::CNT_W'(appc_pkg::CAPTURE_BYTES - 1));
  assign addr_hit = !capturing && ({prior_byte, rx_byte} == device_address);

  always_comb begin
    for (int j = 0; j < appc_pkg::CAPTURE_BYTES; j++) begin
      cap_full[j] = (j == appc_pkg::CAPTURE_BYTES - 1) ? rx_byte : capture_buffer[j];
    end
  end

  assign diff = $signed({1'b0, setpoint_store[ch_sel]}) - $signed({7'b0, sample_value});
  assign prod = $signed({1'b0, gain}) * diff;

  always_comb begin
    if (prod > 27'sd400) begin
      cmd = 10'sd400;
    end else if (prod < -27'sd400) begin
      cmd = -10'sd400;
    end else begin
      cmd = prod[9:0];
    end
  end

  always_comb begin
    job               = '0;
    job.valve_channel = sample_channel;
    job.valve_command = cmd;
    job.reply[0]      = device_address[15:8];
    job.reply[1]      = device_address[7:0];
    for (int i = 0; i < appc_pkg::CHANNELS; i++) begin
      job.reply[2 + 2 * i] = {6'b0, pressure_store[i][9:8]};
      job.reply[3 + 2 * i] = pressure_store[i][7:0];
    end
    case (kind)
      appc_pkg::KIND_BYTE: begin
        job.valid    = pend_valid && cap_done;
        job.is_reply = 1'b1;
      end
      appc_pkg::KIND_SAMPLE: begin
        job.valid    = pend_valid && ch_ok;
        job.is_reply = 1'b0;
      end
      default: begin
        job.valid    = 1'b0;
        job.is_reply = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_byte    <= '0;
      capturing     <= 1'b0;
      capture_count <= '0;
      for (int i = 0; i < appc_pkg::CHANNELS; i++) begin
        setpoint_store[i] <= '0;
        pressure_store[i] <= '0;
      end
    end else if (advance) begin
      case (kind)
        appc_pkg::KIND_BYTE: begin
          if (capturing) begin
            capture_buffer[capture_count] <= rx_byte;
            if (cap_done) begin
              for (int i = 0; i < appc_pkg::CHANNELS; i++) begin
                setpoint_store[i] <= {cap_full[2 * i], cap_full[2 * i + 1]};
              end
              capturing     <= 1'b0;
              capture_count <= '0;
              prior_byte    <= '0;
            end else begin
              capture_count <= capture_count + 1'b1;
            end
          end else if (addr_hit) begin
            capturing     <= 1'b1;
            capture_count <= '0;
            prior_byte    <= '0;
          end else begin
            prior_byte <= rx_byte;
          end
        end
        appc_pkg::KIND_TIMEOUT: begin
          capturing     <= 1'b0;
          capture_count <= '0;
          prior_byte    <= '0;
        end
        appc_pkg::KIND_SAMPLE: begin
          if (ch_ok) begin
            pressure_store[ch_sel] <= sample_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/appc_out.sv =====
// Output register and reply serializer.
// Depends on appc_pkg. Takes a job and presents its result transactions one at a time.
module appc_out (
  input  logic                clk,
  input  logic                rst,
  input  appc_pkg::job_t      job,
  output logic                free,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // valve_channel, valve_command, tx_byte, pad
  output logic                m_axis_tuser,   // out_kind
  output logic                m_axis_tlast
);

  logic                                        out_valid;
  logic                                        out_kind;
  logic [1:0]                                  valve_channel;
  logic signed [9:0]                           valve_command;
  logic [7:0]                                  tx_byte;
  logic                                        last;
  logic [appc_pkg::REM_W-1:0]                  remaining;
  logic [appc_pkg::REPLY_BYTES-1:0][7:0]       pending;
  logic                                        load;
  logic                                        taken;

  assign taken = out_valid && m_axis_tready;
  assign free  = !out_valid || (m_axis_tready && (remaining == '0));
  assign load  = free && job.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remaining <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      remaining <= job.is_reply ? appc_pkg::REM_W'(appc_pkg::REPLY_BYTES - 1) : '0;
    end else if (taken) begin
      if (remaining != '0) begin
        remaining <= remaining - 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= job.is_reply ? appc_pkg::OUT_REPLY : appc_pkg::OUT_VALVE;
      pending  <= job.reply >> 8;
      if (job.is_reply) begin
        valve_channel <= '0;
        valve_command <= '0;
        tx_byte       <= job.reply[0];
        last          <= 1'b0;
      end else begin
        valve_channel <= job.valve_channel;
        valve_command <= job.valve_command;
        tx_byte       <= '0;
        last          <= 1'b1;
      end
    end else if (taken && (remaining != '0)) begin
      tx_byte <= pending[0];
      pending <= pending >> 8;
      last    <= (remaining == appc_pkg::REM_W'(1));
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, tx_byte, valve_command, valve_channel};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = last;

endmodule

// ===== rtl/addressed_packet_pressure_controller.sv =====
// Top level of the addressed packet pressure controller.
// Depends on appc_pkg, appc_ctrl and appc_out; holds the input register and configuration.
//
// Each input transaction is taken into an input register and processed there, where serial
// bytes advance the address window or capture, and pressure samples update the store and
// yield one valve command. A completed capture yields a reply of 2 + 2*CHANNELS bytes (ten
// at four channels), one result transaction per ready cycle from the output register. With
// the output side ready, one input transaction is accepted every cycle; a reply holds off
// input that produces results for its length, set by the output serializer. The valve
// command is gain times (setpoint minus sample), clamped to plus or minus 400. Configuration
// writes take effect at the next clock edge and should only be made while the block is idle.
module addressed_packet_pressure_controller (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // rx_byte, sample_channel, sample_value, pad
  input  logic [1:0]   s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // valve_channel, valve_command, tx_byte, pad
  output logic         m_axis_tuser,   // out_kind
  output logic         m_axis_tlast
);

  logic [15:0]     device_address;
  logic [8:0]      gain;
  logic            pend_valid;
  logic [1:0]      kind;
  logic [7:0]      rx_byte;
  logic [1:0]      sample_channel;
  logic [9:0]      sample_value;
  logic            advance;
  logic            out_free;
  appc_pkg::job_t  job;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 16'hFFFF;
      gain           <= 9'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        appc_pkg::CFG_ADDRESS: device_address <= cfg_data;
        appc_pkg::CFG_GAIN:    gain           <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  assign advance       = pend_valid && (!job.valid || out_free);
  assign s_axis_tready = !pend_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_axis_tready) begin
      pend_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind           <= s_axis_tuser;
      rx_byte        <= s_axis_tdata[7:0];
      sample_channel <= s_axis_tdata[9:8];
      sample_value   <= s_axis_tdata[19:10];
    end
  end

  appc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .pend_valid     (pend_valid),
    .advance        (advance),
    .kind           (kind),
    .rx_byte        (rx_byte),
    .sample_channel (sample_channel),
    .sample_value   (sample_value),
    .device_address (device_address),
    .gain           (gain),
    .job            (job)
  );

  appc_out u_out (
    .clk           (clk),
    .rst           (rst),
    .job           (job),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
